// ===== src/aet_pkg.sv =====
// Shared types and codes for the assembler expression tokenizer.
// Used by aet_lexer and asm_expression_tokenizer_top; no dependencies.
package aet_pkg;

    typedef enum logic [7:0] {
        M_BEGIN  = 8'b0000_0001,
        M_END    = 8'b0000_0010,
        M_CONST  = 8'b0000_0100,
        M_PREFIX = 8'b0000_1000,
        M_CHAR   = 8'b0001_0000,
        M_BINARY = 8'b0010_0000,
        M_LABEL  = 8'b0100_0000,
        M_STOP   = 8'b1000_0000
    } t_mode;

    localparam logic [1:0] RK_TOKEN = 2'd0;
    localparam logic [1:0] RK_ERROR = 2'd1;
    localparam logic [1:0] RK_DONE  = 2'd2;

    localparam logic [2:0] TK_CONST  = 3'd0;
    localparam logic [2:0] TK_PREFIX = 3'd1;
    localparam logic [2:0] TK_CHAR   = 3'd2;
    localparam logic [2:0] TK_UNARY  = 3'd3;
    localparam logic [2:0] TK_BINARY = 3'd4;
    localparam logic [2:0] TK_LPAREN = 3'd5;
    localparam logic [2:0] TK_RPAREN = 3'd6;
    localparam logic [2:0] TK_LABEL  = 3'd7;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_BEGIN  = 3'd1;
    localparam logic [2:0] ERR_EXPECT_EXP = 3'd2;
    localparam logic [2:0] ERR_BAD_END    = 3'd3;
    localparam logic [2:0] ERR_EXPECT_QT  = 3'd4;
    localparam logic [2:0] ERR_END_IN_CHR = 3'd5;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd6;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] pos;
        logic [15:0] start;
        logic [2:0]  kind;
    } t_state;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [2:0]  error_code;
        logic [7:0]  offending_char;
        logic        last;
    } t_result;

endpackage

// ===== src/aet_lexer.sv =====
// Combinational lexer step: one word plus current state gives up to two
// results and the next state. Depends on aet_pkg.
module aet_lexer #(
    parameter int unsigned MAX_LEN = 65535
) (
    input  aet_pkg::t_state  i_state,
    input  logic [7:0]       i_mark,
    input  logic             i_opcode,
    input  logic [7:0]       i_ch,
    output aet_pkg::t_state  o_next,
    output logic [1:0]       o_count,
    output aet_pkg::t_result o_res0,
    output aet_pkg::t_result o_res1
);

    localparam logic [15:0] LIMIT = 16'((MAX_LEN < 65535) ? MAX_LEN : 65535);

    typedef struct packed {
        logic            has;
        aet_pkg::t_result res;
        aet_pkg::t_mode  mode;
        logic [15:0]     start;
        logic [2:0]      kind;
        logic            again;
    } t_pass;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // only O, H, o, h get here since B, D, b, d are hex digits
    function automatic logic is_suffix(input logic [7:0] c);
        return c == "O" || c == "H" || c == "o" || c == "h";
    endfunction

    function automatic logic is_prefix(input logic [7:0] c);
        return c == "%" || c == "@" || c == "$";
    endfunction

    function automatic logic is_cmp(input logic [7:0] c);
        return c == "<" || c == ">" || c == "=";
    endfunction

    function automatic logic is_binop(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
               c == "!" || c == "&" || c == "|" || c == "^" || is_cmp(c);
    endfunction

    function automatic aet_pkg::t_result tok(input logic [2:0] tk,
                                             input logic [15:0] st,
                                             input logic [15:0] ln);
        aet_pkg::t_result r;
        r = '0;
        r.result_kind  = aet_pkg::RK_TOKEN;
        r.token_kind   = tk;
        r.token_start  = st;
        r.token_length = ln;
        return r;
    endfunction

    function automatic aet_pkg::t_result err(input logic [2:0] code,
                                             input logic [7:0] oc);
        aet_pkg::t_result r;
        r = '0;
        r.result_kind    = aet_pkg::RK_ERROR;
        r.error_code     = code;
        r.offending_char = oc;
        return r;
    endfunction

    function automatic aet_pkg::t_result done();
        aet_pkg::t_result r;
        r = '0;
        r.result_kind = aet_pkg::RK_DONE;
        return r;
    endfunction

    function automatic t_pass lex_pass(input aet_pkg::t_mode mode,
                                       input logic [15:0] pos,
                                       input logic [15:0] st,
                                       input logic [2:0] kd,
                                       input logic [7:0] c,
                                       input logic [7:0] mark);
        t_pass       p;
        logic [15:0] span;
        logic [15:0] span1;
        span  = pos - st;
        span1 = span + 16'd1;
        p       = '0;
        p.mode  = mode;
        p.start = st;
        p.kind  = kd;
        case (mode)
            aet_pkg::M_BEGIN: begin
                if (is_space(c)) begin
                end else if (c == "~" || c == "-") begin
                    p.has = 1'b1;
                    p.res = tok(aet_pkg::TK_UNARY, pos, 16'd1);
                end else if (is_digit(c)) begin
                    p.start = pos;
                    p.kind  = aet_pkg::TK_CONST;
                    p.mode  = aet_pkg::M_CONST;
                end else if (is_prefix(c)) begin
                    p.start = pos;
                    p.kind  = aet_pkg::TK_PREFIX;
                    p.mode  = aet_pkg::M_PREFIX;
                end else if (c == "'") begin
                    p.start = pos;
                    p.kind  = aet_pkg::TK_CHAR;
                    p.mode  = aet_pkg::M_CHAR;
                end else if (c == "(") begin
                    p.has = 1'b1;
                    p.res = tok(aet_pkg::TK_LPAREN, pos, 16'd1);
                end else if (is_letter(c) || (c != 8'd0 && c == mark)) begin
                    p.start = pos;
                    p.kind  = aet_pkg::TK_LABEL;
                    p.mode  = aet_pkg::M_LABEL;
                end else begin
                    p.has  = 1'b1;
                    p.res  = err(aet_pkg::ERR_BAD_BEGIN, c);
                    p.mode = aet_pkg::M_STOP;
                end
            end
            aet_pkg::M_END: begin
                if (is_space(c)) begin
                end else if (is_binop(c)) begin
                    p.start = pos;
                    p.kind  = aet_pkg::TK_BINARY;
                    p.mode  = aet_pkg::M_BINARY;
                end else if (c == ")") begin
                    p.has = 1'b1;
                    p.res = tok(aet_pkg::TK_RPAREN, pos, 16'd1);
                end else begin
                    p.has  = 1'b1;
                    p.res  = err(aet_pkg::ERR_BAD_END, c);
                    p.mode = aet_pkg::M_STOP;
                end
            end
            aet_pkg::M_CONST: begin
                if (is_hex(c)) begin
                end else if (is_suffix(c)) begin
                    p.has  = 1'b1;
                    p.res  = tok(kd, st, span1);
                    p.mode = aet_pkg::M_END;
                end else begin
                    p.has   = 1'b1;
                    p.res   = tok(kd, st, span);
                    p.mode  = aet_pkg::M_END;
                    p.again = 1'b1;
                end
            end
            aet_pkg::M_PREFIX: begin
                if (!is_hex(c)) begin
                    p.has   = 1'b1;
                    p.res   = tok(kd, st, span);
                    p.mode  = aet_pkg::M_END;
                    p.again = 1'b1;
                end
            end
            aet_pkg::M_CHAR: begin
                // the quoted character itself is taken as is
                if (span == 16'd1) begin
                end else if (c == "'") begin
                    p.has  = 1'b1;
                    p.res  = tok(kd, st, span1);
                    p.mode = aet_pkg::M_END;
                end else begin
                    p.has  = 1'b1;
                    p.res  = err(aet_pkg::ERR_EXPECT_QT, c);
                    p.mode = aet_pkg::M_STOP;
                end
            end
            aet_pkg::M_BINARY: begin
                p.has   = 1'b1;
                p.res   = tok(kd, st, is_cmp(c) ? span1 : span);
                p.again = !is_cmp(c);
                p.mode  = aet_pkg::M_BEGIN;
            end
            aet_pkg::M_LABEL: begin
                if (!(c == "_" || is_digit(c) || is_letter(c))) begin
                    p.has   = 1'b1;
                    p.res   = tok(kd, st, span);
                    p.mode  = aet_pkg::M_END;
                    p.again = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return p;
    endfunction

    t_pass       p1;
    t_pass       p2;
    logic [15:0] span;

    always_comb begin
        span    = i_state.pos - i_state.start;
        o_next  = i_state;
        o_count = 2'd0;
        o_res0  = '0;
        o_res1  = '0;
        p1      = '0;
        p2      = '0;
        if (i_opcode) begin
            case (i_state.mode)
                aet_pkg::M_BEGIN: begin
                    o_res0  = err(aet_pkg::ERR_EXPECT_EXP, 8'd0);
                    o_count = 2'd1;
                end
                aet_pkg::M_END: begin
                    o_res0  = done();
                    o_count = 2'd1;
                end
                aet_pkg::M_CONST, aet_pkg::M_PREFIX, aet_pkg::M_LABEL: begin
                    o_res0  = tok(i_state.kind, i_state.start, span);
                    o_res1  = done();
                    o_count = 2'd2;
                end
                aet_pkg::M_CHAR: begin
                    o_res0  = err(aet_pkg::ERR_END_IN_CHR, 8'd0);
                    o_count = 2'd1;
                end
                aet_pkg::M_BINARY: begin
                    o_res0  = tok(i_state.kind, i_state.start, span);
                    o_res1  = err(aet_pkg::ERR_EXPECT_EXP, 8'd0);
                    o_count = 2'd2;
                end
                default: begin
                end
            endcase
            // restart for the next string
            o_next.mode  = aet_pkg::M_BEGIN;
            o_next.pos   = 16'd0;
            o_next.start = 16'd0;
            o_next.kind  = 3'd0;
        end else if (i_state.mode != aet_pkg::M_STOP) begin
            if (i_state.pos >= LIMIT) begin
                o_res0      = err(aet_pkg::ERR_TOO_LONG, i_ch);
                o_count     = 2'd1;
                o_next.mode = aet_pkg::M_STOP;
            end else begin
                p1 = lex_pass(i_state.mode, i_state.pos, i_state.start,
                              i_state.kind, i_ch, i_mark);
                if (p1.again) begin
                    p2 = lex_pass(p1.mode, i_state.pos, p1.start, p1.kind,
                                  i_ch, i_mark);
                end else begin
                    p2      = '0;
                    p2.mode = p1.mode;
                    p2.start = p1.start;
                    p2.kind = p1.kind;
                end
                o_next.mode  = p2.mode;
                o_next.start = p2.start;
                o_next.kind  = p2.kind;
                o_next.pos   = i_state.pos + 16'd1;
                if (p1.has && p2.has) begin
                    o_res0  = p1.res;
                    o_res1  = p2.res;
                    o_count = 2'd2;
                end else if (p1.has) begin
                    o_res0  = p1.res;
                    o_count = 2'd1;
                end else if (p2.has) begin
                    o_res0  = p2.res;
                    o_count = 2'd1;
                end
            end
        end
        // mark the final result of this word
        if (o_count == 2'd2) begin
            o_res1.last = 1'b1;
        end else if (o_count == 2'd1) begin
            o_res0.last = 1'b1;
        end
    end

endmodule

// ===== src/asm_expression_tokenizer_top.sv =====
// A result is registered and offered in the cycle after its input word is accepted.
// One input word per cycle while each word gives at most one result and the
// output is not stalled; a word that gives two results holds off the next word
// while the single output port drains the two-entry result buffer.
// Reset (synchronous, active low) clears the lexer state and the label mark
// and empties the result buffer; no clearing pass is needed.
// Top level: result buffer, state registers, label-mark register.
// Depends on aet_pkg and aet_lexer.
module asm_expression_tokenizer_top #(
    parameter int unsigned MAX_LEN = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_ch,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic [2:0]  o_error_code,
    output logic [7:0]  o_offending_char,
    output logic        o_last
);

    aet_pkg::t_state  r_state;
    aet_pkg::t_state  n_state;
    logic [7:0]       r_mark;
    logic [1:0]       r_cnt;
    aet_pkg::t_result r_q0;
    aet_pkg::t_result r_q1;
    logic [1:0]       n_count;
    aet_pkg::t_result n_res0;
    aet_pkg::t_result n_res1;
    logic             accept;
    logic             pop;

    aet_lexer #(
        .MAX_LEN (MAX_LEN)
    ) u_lexer (
        .i_state  (r_state),
        .i_mark   (r_mark),
        .i_opcode (i_opcode),
        .i_ch     (i_ch),
        .o_next   (n_state),
        .o_count  (n_count),
        .o_res0   (n_res0),
        .o_res1   (n_res1)
    );

    assign o_out_valid = (r_cnt != 2'd0);
    assign pop         = o_out_valid && i_out_ready;
    // take a word when the buffer is empty or its only entry leaves now
    assign o_in_ready  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign accept      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode  <= aet_pkg::M_BEGIN;
            r_state.pos   <= 16'd0;
            r_state.start <= 16'd0;
            r_state.kind  <= 3'd0;
            r_mark        <= 8'd0;
            r_cnt         <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_mark <= i_cfg_wdata;
            end
            if (accept) begin
                r_state <= n_state;
                r_cnt   <= n_count;
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q0 <= n_res0;
            r_q1 <= n_res1;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

    assign o_result_kind    = r_q0.result_kind;
    assign o_token_kind     = r_q0.token_kind;
    assign o_token_start    = r_q0.token_start;
    assign o_token_length   = r_q0.token_length;
    assign o_error_code     = r_q0.error_code;
    assign o_offending_char = r_q0.offending_char;
    assign o_last           = r_q0.last;

endmodule
